/* hw/rtl/mava_pkg.sv */
// Shared types and constants for the moving average / variance alarm block.
// No dependencies; used by the top level and mava_arith.
package mava_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DQ_W     = 38;
    localparam int STEP_W   = 6;
    localparam int DIVS_W   = 7;
    localparam int REM_W    = 8;
    localparam int HYST_W   = 17;

    localparam logic [9:0] HYST_BASE = 10'd1000;

    localparam logic [2:0] REG_AVERAGE_LENGTH      = 3'd0;
    localparam logic [2:0] REG_WINDOW_LENGTH       = 3'd1;
    localparam logic [2:0] REG_DEVIATION_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_EXPECTED_LEVEL      = 3'd3;
    localparam logic [2:0] REG_ALARM_DELAY         = 3'd4;
    localparam logic [2:0] REG_SHAKE_NEEDED        = 3'd5;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_HIGH   = 2'd1,
        ST_LOW    = 2'd2,
        ST_SHAKE  = 2'd3
    } alarm_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [STEP_W-1:0] steps;
    } arith_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_SQ,
        S_VDIV,
        S_LIM,
        S_MDIV,
        S_ADIV,
        S_ALARM
    } seq_state_t;

endpackage

/* hw/rtl/moving_average_variance_alarm_unit.sv */
// Top level: sequencer, state and alarm for the moving average / variance block.
// Depends on mava_pkg, mava_ram and mava_arith.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, sample                | into block
//  out     | out_valid, out_stall, average_out,        | out of block
//          | alarm_status, noisy_blocks                |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// An ordinary item runs ring update, square and average divide; the item that closes a block
// runs variance divide, limit multiply, mean divide and average divide on the bit-serial unit.
// One item at a time: in_stall is high from transfer until the result is registered.
// Reset clears control registers; ring entries carry valid bits and read as zero until written.
// A stalled result holds; the next item's alarm step waits until the result register is free.
module moving_average_variance_alarm_unit #(
    parameter int AVERAGE_MAX = 64,
    parameter int BLOCKS_MAX  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] average_out,
    output logic [1:0]  alarm_status,
    output logic [15:0] noisy_blocks,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W  = $clog2(AVERAGE_MAX);
    localparam int RING_N = (AVERAGE_MAX < 127) ? AVERAGE_MAX : 127;
    localparam int RSW    = $clog2(RING_N) + 16;

    mava_pkg::seq_state_t      state_reg, state_next;
    mava_pkg::arith_req_t      req;
    logic [mava_pkg::DQ_W-1:0] opa;
    logic [15:0]               opb;
    logic                      ar_busy, ar_done;
    logic [mava_pkg::DQ_W-1:0] ar_res;

    logic [6:0]  avg_len_reg;
    logic [4:0]  win_len_reg;
    logic [15:0] thr_reg, exp_reg, delay_reg, need_reg;

    logic [AVERAGE_MAX-1:0] vld_reg, vld_next;
    logic [RSW-1:0]   ring_sum_reg, ring_sum_next;
    logic [6:0]       ring_idx_reg, ring_idx_next;
    logic [37:0]      var_reg, var_next;
    logic [4:0]       pos_reg, pos_next;
    logic [3:0]       bn_reg, bn_next;
    logic [19:0]      total_reg, total_next;
    logic [15:0]      prev_reg, prev_next;
    logic [15:0]      flags_reg, flags_next;
    logic [15:0]      shk_reg, shk_next;
    logic [16:0]      hyst_reg, hyst_next;
    mava_pkg::alarm_t status_reg, status_next;
    logic [15:0]      smp_reg, smp_next;
    logic [15:0]      avg_reg, avg_next;
    logic             ov_reg, ov_next;
    logic [15:0]      oavg_reg, oavg_next;
    logic [1:0]       ost_reg, ost_next;
    logic [15:0]      oflg_reg, oflg_next;

    logic [6:0]       alen;
    logic [4:0]       wlen;
    logic [3:0]       blk;
    logic [15:0]      old_smp, rd_data, dif;
    logic             wr_en;
    logic [4:0]       bn_inc;
    logic             shake, abnormal;
    logic [16:0]      bound;
    logic             slot_free;

    mava_ram #(.WIDTH(16), .DEPTH(AVERAGE_MAX)) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(ring_idx_reg)),
        .wr_data (smp_reg),
        .rd_addr (IDX_W'(ring_idx_reg)),
        .rd_data (rd_data)
    );

    mava_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .opa    (opa),
        .opb    (opb),
        .busy   (ar_busy),
        .done   (ar_done),
        .result (ar_res)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_len_reg <= 7'd16;
            win_len_reg <= 5'd8;
            thr_reg     <= 16'd100;
            exp_reg     <= 16'd0;
            delay_reg   <= 16'd100;
            need_reg    <= 16'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mava_pkg::REG_AVERAGE_LENGTH:      avg_len_reg <= cfg_data[6:0];
                mava_pkg::REG_WINDOW_LENGTH:       win_len_reg <= cfg_data[4:0];
                mava_pkg::REG_DEVIATION_THRESHOLD: thr_reg     <= cfg_data;
                mava_pkg::REG_EXPECTED_LEVEL:      exp_reg     <= cfg_data;
                mava_pkg::REG_ALARM_DELAY:         delay_reg   <= cfg_data;
                mava_pkg::REG_SHAKE_NEEDED:        need_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mava_pkg::S_IDLE;
            vld_reg      <= '0;
            ring_sum_reg <= '0;
            ring_idx_reg <= '0;
            pos_reg      <= '0;
            bn_reg       <= '0;
            total_reg    <= '0;
            prev_reg     <= '0;
            flags_reg    <= '0;
            shk_reg      <= '0;
            hyst_reg     <= '0;
            status_reg   <= mava_pkg::ST_NORMAL;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            ring_sum_reg <= ring_sum_next;
            ring_idx_reg <= ring_idx_next;
            pos_reg      <= pos_next;
            bn_reg       <= bn_next;
            total_reg    <= total_next;
            prev_reg     <= prev_next;
            flags_reg    <= flags_next;
            shk_reg      <= shk_next;
            hyst_reg     <= hyst_next;
            status_reg   <= status_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg  <= var_next;
        smp_reg  <= smp_next;
        avg_reg  <= avg_next;
        oavg_reg <= oavg_next;
        ost_reg  <= ost_next;
        oflg_reg <= oflg_next;
    end

    always_comb
    begin
        if (avg_len_reg == 7'd0)
        begin
            alen = 7'd1;
        end
        else if (int'(avg_len_reg) > AVERAGE_MAX)
        begin
            alen = 7'(AVERAGE_MAX);
        end
        else
        begin
            alen = avg_len_reg;
        end
        if (win_len_reg == 5'd0)
        begin
            wlen = 5'd1;
        end
        else if (int'(win_len_reg) > BLOCKS_MAX)
        begin
            wlen = 5'(BLOCKS_MAX);
        end
        else
        begin
            wlen = win_len_reg;
        end
    end

    assign blk       = bn_reg & 4'(BLOCKS_MAX - 1);
    assign old_smp   = vld_reg[IDX_W'(ring_idx_reg)] ? rd_data : 16'd0;
    assign dif       = (smp_reg >= prev_reg) ? smp_reg - prev_reg : prev_reg - smp_reg;
    assign bn_inc    = {1'b0, bn_reg} + 5'd1;
    assign slot_free = !ov_reg || !out_stall;
    assign bound     = {7'd0, mava_pkg::HYST_BASE} + {1'b0, delay_reg};
    assign shake     = (flags_reg != 16'd0) && (shk_reg >= need_reg);
    assign abnormal  = shake
        || ((avg_reg >= exp_reg) ? (avg_reg - exp_reg) : (exp_reg - avg_reg)) > thr_reg;
    assign in_stall  = (state_reg != mava_pkg::S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        vld_next      = vld_reg;
        ring_sum_next = ring_sum_reg;
        ring_idx_next = ring_idx_reg;
        var_next      = var_reg;
        pos_next      = pos_reg;
        bn_next       = bn_reg;
        total_next    = total_reg;
        prev_next     = prev_reg;
        flags_next    = flags_reg;
        shk_next      = shk_reg;
        hyst_next     = hyst_reg;
        status_next   = status_reg;
        smp_next      = smp_reg;
        avg_next      = avg_reg;
        ov_next       = ov_reg && out_stall;
        oavg_next     = oavg_reg;
        ost_next      = ost_reg;
        oflg_next     = oflg_reg;
        wr_en         = 1'b0;
        req           = '{start: 1'b0, op: mava_pkg::OP_MUL, steps: '0};
        opa           = (mava_pkg::DQ_W'(ring_sum_reg)) << (mava_pkg::DQ_W - RSW);
        opb           = {9'd0, alen};

        case (state_reg)
            mava_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next   = sample;
                    state_next = mava_pkg::S_RING;
                end
            end
            mava_pkg::S_RING:
            begin
                if (ring_idx_reg >= alen)
                begin
                    ring_idx_next = '0;
                end
                else
                begin
                    ring_sum_next = ring_sum_reg + RSW'(smp_reg) - RSW'(old_smp);
                    wr_en         = 1'b1;
                    vld_next[IDX_W'(ring_idx_reg)] = 1'b1;
                    ring_idx_next = ring_idx_reg + 7'd1;
                end
                if (pos_reg >= wlen)
                begin
                    req        = '{start: 1'b1, op: mava_pkg::OP_DIV, steps: 6'd38};
                    opa        = var_reg;
                    opb        = {11'd0, wlen};
                    state_next = mava_pkg::S_VDIV;
                end
                else
                begin
                    req        = '{start: 1'b1, op: mava_pkg::OP_MUL, steps: 6'd16};
                    opa        = {22'd0, dif};
                    opb        = dif;
                    state_next = mava_pkg::S_SQ;
                end
            end
            mava_pkg::S_SQ:
            begin
                if (ar_done)
                begin
                    var_next   = (pos_reg == 5'd0) ? ar_res : var_reg + ar_res;
                    total_next = total_reg + {4'd0, smp_reg};
                    pos_next   = pos_reg + 5'd1;
                    req        = '{start: 1'b1, op: mava_pkg::OP_DIV,
                                   steps: mava_pkg::STEP_W'(RSW)};
                    state_next = mava_pkg::S_ADIV;
                end
            end
            mava_pkg::S_VDIV:
            begin
                if (ar_done)
                begin
                    var_next   = ar_res;
                    req        = '{start: 1'b1, op: mava_pkg::OP_MUL, steps: 6'd16};
                    opa        = {22'd0, thr_reg};
                    opb        = thr_reg;
                    state_next = mava_pkg::S_LIM;
                end
            end
            mava_pkg::S_LIM:
            begin
                if (ar_done)
                begin
                    if (var_reg > {6'd0, ar_res[31:0]})
                    begin
                        flags_next[blk] = 1'b1;
                        if (shk_reg < need_reg)
                        begin
                            shk_next = shk_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        flags_next[blk] = 1'b0;
                    end
                    if (bn_inc >= wlen)
                    begin
                        bn_next  = '0;
                        shk_next = '0;
                    end
                    else
                    begin
                        bn_next = bn_inc[3:0];
                    end
                    pos_next   = '0;
                    req        = '{start: 1'b1, op: mava_pkg::OP_DIV, steps: 6'd20};
                    opa        = {total_reg, 18'd0};
                    opb        = {11'd0, wlen};
                    state_next = mava_pkg::S_MDIV;
                end
            end
            mava_pkg::S_MDIV:
            begin
                if (ar_done)
                begin
                    prev_next  = (ar_res[19:16] != 4'd0) ? 16'hFFFF : ar_res[15:0];
                    total_next = '0;
                    req        = '{start: 1'b1, op: mava_pkg::OP_DIV,
                                   steps: mava_pkg::STEP_W'(RSW)};
                    state_next = mava_pkg::S_ADIV;
                end
            end
            mava_pkg::S_ADIV:
            begin
                if (ar_done)
                begin
                    avg_next   = (ar_res[mava_pkg::DQ_W-1:16] != '0) ? 16'hFFFF
                                                                    : ar_res[15:0];
                    state_next = mava_pkg::S_ALARM;
                end
            end
            mava_pkg::S_ALARM:
            begin
                if (slot_free)
                begin
                    if (abnormal)
                    begin
                        if (hyst_reg > bound)
                        begin
                            if (shake)
                            begin
                                status_next = mava_pkg::ST_SHAKE;
                            end
                            else if (avg_reg > exp_reg)
                            begin
                                status_next = mava_pkg::ST_HIGH;
                            end
                            else
                            begin
                                status_next = mava_pkg::ST_LOW;
                            end
                        end
                        else
                        begin
                            hyst_next = hyst_reg + 17'd1;
                        end
                    end
                    else if (hyst_reg > {7'd0, mava_pkg::HYST_BASE})
                    begin
                        hyst_next = hyst_reg - 17'd1;
                    end
                    else
                    begin
                        status_next = mava_pkg::ST_NORMAL;
                    end
                    ov_next    = 1'b1;
                    oavg_next  = avg_reg;
                    ost_next   = status_next;
                    oflg_next  = flags_reg;
                    state_next = mava_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mava_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign average_out  = oavg_reg;
    assign alarm_status = ost_reg;
    assign noisy_blocks = oflg_reg;

    a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ar_busy |-> (state_reg == mava_pkg::S_SQ || state_reg == mava_pkg::S_VDIV
                     || state_reg == mava_pkg::S_LIM || state_reg == mava_pkg::S_MDIV
                     || state_reg == mava_pkg::S_ADIV))
        else $error("arithmetic unit busy outside a wait state");

    a_out_from_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mava_pkg::S_ALARM))
        else $error("result raised without alarm step");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 5'd16)
        else $error("block position out of range");

    a_ring_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == mava_pkg::S_RING && $past(state_reg == mava_pkg::S_IDLE))
        else $error("ring written outside its step");

endmodule

/* hw/rtl/mava_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mava_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/mava_arith.sv */
// Shared iterative unit: 16x16 shift-add multiply and restoring divide.
// Depends on mava_pkg.
module mava_arith (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mava_pkg::arith_req_t               req,
    input  logic [mava_pkg::DQ_W-1:0]          opa,
    input  logic [mava_pkg::SAMPLE_W-1:0]      opb,
    output logic                               busy,
    output logic                               done,
    output logic [mava_pkg::DQ_W-1:0]          result
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    mava_pkg::arith_op_t             op_reg, op_next;
    logic [mava_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [mava_pkg::DQ_W-1:0]       dq_reg, dq_next;
    logic [mava_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [mava_pkg::SAMPLE_W-1:0]   b_reg, b_next;
    logic [mava_pkg::REM_W-1:0]      trial;
    logic [16:0]                     psum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        trial     = {rem_reg[mava_pkg::REM_W-2:0], dq_reg[mava_pkg::DQ_W-1]};
        psum      = {1'b0, dq_reg[31:16]} + (dq_reg[0] ? {1'b0, b_reg} : 17'd0);
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = req.steps;
            rem_next  = '0;
            b_next    = opb;
            if (req.op == mava_pkg::OP_MUL)
            begin
                dq_next = {22'd0, opa[15:0]};
            end
            else
            begin
                dq_next = opa;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == mava_pkg::OP_MUL)
            begin
                dq_next = {6'd0, psum, dq_reg[15:1]};
            end
            else if (trial >= {1'b0, b_reg[mava_pkg::DIVS_W-1:0]})
            begin
                rem_next = trial - {1'b0, b_reg[mava_pkg::DIVS_W-1:0]};
                dq_next  = {dq_reg[mava_pkg::DQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dq_next  = {dq_reg[mava_pkg::DQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mava_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = dq_reg;

endmodule
